FILE: rtl/tsv_pkg.sv
// ----------------------------------------------------------------------------
// tsv_pkg
// Shared types and constants for the timestamp syntax validator.
// ----------------------------------------------------------------------------
package tsv_pkg;

  localparam int unsigned MaxLengthDef = 64;
  localparam int unsigned MinLength    = 20;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned QueuePtrW    = $clog2(QueueDepth);
  localparam int unsigned QueueCntW    = $clog2(QueueDepth + 1);

  // character classes produced by the front end
  typedef enum logic [3:0] {
    CLS_DIGIT,
    CLS_DASH,
    CLS_COLON,
    CLS_T,
    CLS_Z,
    CLS_PLUS,
    CLS_DOT,
    CLS_NUL,
    CLS_OTHER
  } char_cls_e;

  typedef enum logic [1:0] {
    ZONE_NONE,
    ZONE_PLUS,
    ZONE_MINUS
  } zone_sign_e;

  typedef struct packed {
    char_cls_e  cls;
    logic [3:0] digit;
    logic       last;
  } token_t;

  // parsed fields of one finished string, handed to the final check
  typedef struct packed {
    logic       form_ok;
    logic [6:0] year_hi;
    logic [6:0] year_lo;
    logic [6:0] month;
    logic [6:0] day;
    logic [6:0] hour;
    logic [6:0] minute;
    logic [6:0] second;
    zone_sign_e zone_sign;
    logic [6:0] zone_hour;
    logic [6:0] zone_minute;
  } snap_t;

endpackage

FILE: rtl/tsv_front.sv
// ----------------------------------------------------------------------------
// tsv_front
// Classifies each incoming byte into a character class and digit value.
// ----------------------------------------------------------------------------
module tsv_front
  import tsv_pkg::*;
(
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       is_last_i,
  output logic       tok_valid_o,
  output token_t     tok_o,
  input  logic       tok_ready_i
);

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharT     = 8'h54;
  localparam logic [7:0] CharZ     = 8'h5A;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;

  logic is_digit;

  assign is_digit = (char_byte_i >= CharZero) && (char_byte_i <= CharNine);

  always_comb begin
    tok_o.last  = is_last_i;
    tok_o.digit = is_digit ? char_byte_i[3:0] : 4'h0;
    tok_o.cls   = CLS_OTHER;
    if (is_digit) begin
      tok_o.cls = CLS_DIGIT;
    end else begin
      unique case (char_byte_i)
        CharNul:   tok_o.cls = CLS_NUL;
        CharDash:  tok_o.cls = CLS_DASH;
        CharColon: tok_o.cls = CLS_COLON;
        CharT:     tok_o.cls = CLS_T;
        CharZ:     tok_o.cls = CLS_Z;
        CharPlus:  tok_o.cls = CLS_PLUS;
        CharDot:   tok_o.cls = CLS_DOT;
        default:   tok_o.cls = CLS_OTHER;
      endcase
    end
  end

  assign tok_valid_o = in_valid_i;
  assign in_ready_o  = tok_ready_i;

endmodule

FILE: rtl/tsv_queue.sv
// ----------------------------------------------------------------------------
// tsv_queue
// Small token queue between the classifier and the parser.
// ----------------------------------------------------------------------------
module tsv_queue
  import tsv_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  token_t push_tok_i,
  output logic   pop_valid_o,
  output token_t pop_tok_o,
  input  logic   pop_ready_i
);

  token_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   count_q;
  logic                   push, pop;

  assign push_ready_o = (count_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_tok_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_tok_i;
    end
  end

endmodule

FILE: rtl/tsv_back.sv
// ----------------------------------------------------------------------------
// tsv_back
// Parser: walks the form and fills fields, one token per cycle; last may stall.
// ----------------------------------------------------------------------------
module tsv_back
  import tsv_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MaxLengthDef
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   tok_valid_i,
  input  token_t tok_i,
  output logic   tok_ready_o,
  output logic   snap_valid_o,
  output snap_t  snap_o,
  input  logic   snap_ready_i
);

  localparam int unsigned PosW = $clog2(MAX_LENGTH + 1);

  typedef enum logic [3:0] {
    PH_FIXED,
    PH_AFTER_SEC,
    PH_DOT,
    PH_FRAC,
    PH_ZH1,
    PH_ZH2,
    PH_ZCOLON,
    PH_ZM1,
    PH_ZM2,
    PH_DONE
  } phase_e;

  logic [PosW-1:0] pos_q, pos_d;
  phase_e          phase_q, phase_d;
  logic [6:0]      year_hi_q, year_hi_d, year_lo_q, year_lo_d;
  logic [6:0]      month_q, month_d, day_q, day_d;
  logic [6:0]      hour_q, hour_d, minute_q, minute_d, second_q, second_d;
  zone_sign_e      zsign_q, zsign_d;
  logic [6:0]      zhour_q, zhour_d, zmin_q, zmin_d;
  logic            err_q, err_d;
  logic            consume, is_dig;

  function automatic logic [6:0] acc10(input logic [6:0] v, input logic [3:0] d);
    acc10 = 7'(({3'b000, v} * 10'd10) + {6'b000000, d});
  endfunction

  assign is_dig       = (tok_i.cls == CLS_DIGIT);
  assign tok_ready_o  = !tok_i.last || snap_ready_i;
  assign consume      = tok_valid_i && tok_ready_o;
  assign snap_valid_o = consume && tok_i.last;

  always_comb begin
    pos_d     = pos_q;
    phase_d   = phase_q;
    year_hi_d = year_hi_q;
    year_lo_d = year_lo_q;
    month_d   = month_q;
    day_d     = day_q;
    hour_d    = hour_q;
    minute_d  = minute_q;
    second_d  = second_q;
    zsign_d   = zsign_q;
    zhour_d   = zhour_q;
    zmin_d    = zmin_q;
    err_d     = err_q;

    if (tok_i.cls == CLS_NUL) begin
      err_d = 1'b1;
    end
    // length saturates at the limit and flags
    if (pos_q >= PosW'(MAX_LENGTH)) begin
      err_d = 1'b1;
    end else begin
      pos_d = pos_q + 1'b1;
    end

    if (!err_d) begin
      unique case (phase_q)
        PH_FIXED: begin
          if (pos_q == PosW'(4) || pos_q == PosW'(7)) begin
            if (tok_i.cls != CLS_DASH) err_d = 1'b1;
          end else if (pos_q == PosW'(10)) begin
            if (tok_i.cls != CLS_T) err_d = 1'b1;
          end else if (pos_q == PosW'(13) || pos_q == PosW'(16)) begin
            if (tok_i.cls != CLS_COLON) err_d = 1'b1;
          end else if (!is_dig || pos_q > PosW'(18)) begin
            err_d = 1'b1;
          end else begin
            // year kept as two two-digit halves
            if (pos_q < PosW'(2)) year_hi_d = acc10(year_hi_q, tok_i.digit);
            else if (pos_q < PosW'(4)) year_lo_d = acc10(year_lo_q, tok_i.digit);
            else if (pos_q < PosW'(7)) month_d = acc10(month_q, tok_i.digit);
            else if (pos_q < PosW'(10)) day_d = acc10(day_q, tok_i.digit);
            else if (pos_q < PosW'(13)) hour_d = acc10(hour_q, tok_i.digit);
            else if (pos_q < PosW'(16)) minute_d = acc10(minute_q, tok_i.digit);
            else second_d = acc10(second_q, tok_i.digit);
            if (pos_q == PosW'(18)) phase_d = PH_AFTER_SEC;
          end
        end
        PH_AFTER_SEC, PH_FRAC: begin
          if (phase_q == PH_AFTER_SEC && tok_i.cls == CLS_DOT) begin
            phase_d = PH_DOT;
          end else if (phase_q == PH_FRAC && is_dig) begin
            phase_d = PH_FRAC;
          end else if (tok_i.cls == CLS_Z) begin
            phase_d = PH_DONE;
          end else if (tok_i.cls == CLS_PLUS) begin
            zsign_d = ZONE_PLUS;
            phase_d = PH_ZH1;
          end else if (tok_i.cls == CLS_DASH) begin
            zsign_d = ZONE_MINUS;
            phase_d = PH_ZH1;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_DOT: begin
          if (is_dig) phase_d = PH_FRAC;
          else err_d = 1'b1;
        end
        PH_ZH1, PH_ZH2: begin
          if (is_dig) begin
            zhour_d = acc10(zhour_q, tok_i.digit);
            phase_d = (phase_q == PH_ZH1) ? PH_ZH2 : PH_ZCOLON;
          end else begin
            err_d = 1'b1;
          end
        end
        PH_ZCOLON: begin
          if (tok_i.cls == CLS_COLON) phase_d = PH_ZM1;
          else err_d = 1'b1;
        end
        PH_ZM1, PH_ZM2: begin
          if (is_dig) begin
            zmin_d  = acc10(zmin_q, tok_i.digit);
            phase_d = (phase_q == PH_ZM1) ? PH_ZM2 : PH_DONE;
          end else begin
            err_d = 1'b1;
          end
        end
        default: err_d = 1'b1;
      endcase
    end
  end

  always_comb begin
    snap_o.form_ok     = !err_d && (phase_d == PH_DONE) && (pos_d >= PosW'(MinLength));
    snap_o.year_hi     = year_hi_d;
    snap_o.year_lo     = year_lo_d;
    snap_o.month       = month_d;
    snap_o.day         = day_d;
    snap_o.hour        = hour_d;
    snap_o.minute      = minute_d;
    snap_o.second      = second_d;
    snap_o.zone_sign   = zsign_d;
    snap_o.zone_hour   = zhour_d;
    snap_o.zone_minute = zmin_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= PH_FIXED;
      year_hi_q <= '0;
      year_lo_q <= '0;
      month_q   <= '0;
      day_q     <= '0;
      hour_q    <= '0;
      minute_q  <= '0;
      second_q  <= '0;
      zsign_q   <= ZONE_NONE;
      zhour_q   <= '0;
      zmin_q    <= '0;
      err_q     <= 1'b0;
    end else if (consume) begin
      if (tok_i.last) begin
        // string finished, start fresh on the next byte
        pos_q     <= '0;
        phase_q   <= PH_FIXED;
        year_hi_q <= '0;
        year_lo_q <= '0;
        month_q   <= '0;
        day_q     <= '0;
        hour_q    <= '0;
        minute_q  <= '0;
        second_q  <= '0;
        zsign_q   <= ZONE_NONE;
        zhour_q   <= '0;
        zmin_q    <= '0;
        err_q     <= 1'b0;
      end else begin
        pos_q     <= pos_d;
        phase_q   <= phase_d;
        year_hi_q <= year_hi_d;
        year_lo_q <= year_lo_d;
        month_q   <= month_d;
        day_q     <= day_d;
        hour_q    <= hour_d;
        minute_q  <= minute_d;
        second_q  <= second_d;
        zsign_q   <= zsign_d;
        zhour_q   <= zhour_d;
        zmin_q    <= zmin_d;
        err_q     <= err_d;
      end
    end
  end

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(MAX_LENGTH))
    else $error("byte position beyond length limit");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (consume && tok_i.last) |=> (pos_q == '0) && (phase_q == PH_FIXED) && !err_q)
    else $error("parser state not cleared after final byte");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && !(consume && tok_i.last)) |=> err_q)
    else $error("error flag dropped within a string");

  a_snap_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snap_valid_o |-> snap_ready_i)
    else $error("snapshot offered while check stage is busy");

endmodule

FILE: rtl/tsv_check.sv
// ----------------------------------------------------------------------------
// tsv_check
// Final range and calendar check on a finished string, with output register.
// ----------------------------------------------------------------------------
module tsv_check
  import tsv_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  snap_valid_i,
  input  snap_t snap_i,
  output logic  snap_ready_o,
  output logic  out_valid_o,
  output logic  valid_res_o,
  input  logic  out_ready_i
);

  localparam logic [19:0] LastSecOfDay = 20'd86399;

  logic        snap_vld_q;
  snap_t       snap_q;
  logic        out_vld_q, res_q;
  logic        out_free, verdict;
  logic        leap, zone_ok, cal_ok, time_ok, edge_ok;
  logic [4:0]  max_day;
  logic [18:0] sod, off;
  logic [19:0] sod_late;

  function automatic logic [4:0] month_days(input logic [6:0] m, input logic lp);
    logic [4:0] d;
    unique case (m)
      7'd2:                      d = lp ? 5'd29 : 5'd28;
      7'd4, 7'd6, 7'd9, 7'd11:   d = 5'd30;
      default:                   d = 5'd31;
    endcase
    month_days = d;
  endfunction

  always_comb begin
    // year = hi*100 + lo, and 100 is a multiple of four
    leap = (snap_q.year_lo[1:0] == 2'b00) &&
           ((snap_q.year_lo != 7'd0) || (snap_q.year_hi[1:0] == 2'b00));
    max_day = month_days(snap_q.month, leap);

    zone_ok = (snap_q.zone_sign == ZONE_NONE) ||
              ((snap_q.zone_hour <= 7'd23) && (snap_q.zone_minute <= 7'd59) &&
               !((snap_q.zone_sign == ZONE_MINUS) && (snap_q.zone_hour == 7'd0) &&
                 (snap_q.zone_minute == 7'd0)));
    cal_ok  = (snap_q.month >= 7'd1) && (snap_q.month <= 7'd12) &&
              (snap_q.day >= 7'd1) && (snap_q.day <= 7'(max_day));
    time_ok = (snap_q.hour <= 7'd23) && (snap_q.minute <= 7'd59) &&
              (snap_q.second <= 7'd60);

    sod = 19'(snap_q.hour) * 19'd3600 + 19'(snap_q.minute) * 19'd60 +
          19'(snap_q.second);
    off = 19'(snap_q.zone_hour) * 19'd3600 + 19'(snap_q.zone_minute) * 19'd60;
    sod_late = 20'(sod) + 20'(off);

    // only the first and last representable dates can leave the range
    edge_ok = 1'b1;
    if ((snap_q.year_hi == 7'd0) && (snap_q.year_lo == 7'd0) &&
        (snap_q.month == 7'd1) && (snap_q.day == 7'd1) &&
        (snap_q.zone_sign == ZONE_PLUS) && (sod < off)) begin
      edge_ok = 1'b0;
    end
    // a leap second on the last day can overflow even without an offset
    if ((snap_q.year_hi == 7'd99) && (snap_q.year_lo == 7'd99) &&
        (snap_q.month == 7'd12) && (snap_q.day == 7'd31) &&
        (((snap_q.zone_sign == ZONE_PLUS) &&
          (20'(sod) > 20'(off) + LastSecOfDay)) ||
         ((snap_q.zone_sign != ZONE_PLUS) && (sod_late > LastSecOfDay)))) begin
      edge_ok = 1'b0;
    end

    verdict = snap_q.form_ok && zone_ok && cal_ok && time_ok && edge_ok;
  end

  assign out_free     = !out_vld_q || out_ready_i;
  assign snap_ready_o = !snap_vld_q || out_free;
  assign out_valid_o  = out_vld_q;
  assign valid_res_o  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (snap_ready_o) begin
        snap_vld_q <= snap_valid_i;
      end
      if (out_free) begin
        out_vld_q <= snap_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_ready_o && snap_valid_i) begin
      snap_q <= snap_i;
    end
    if (out_free && snap_vld_q) begin
      res_q <= verdict;
    end
  end

endmodule

FILE: rtl/timestamp_syntax_validator.sv
// ----------------------------------------------------------------------------
// timestamp_syntax_validator
// Byte-serial checker for date-time strings with zone offset.
//
//   channel | handshake               | payload
//   --------+-------------------------+---------------------------
//   input   | in_valid_i / in_ready_o | char_byte_i, is_last_i
//   output  | out_valid_o/out_ready_i | valid_res_o
//
// One byte is taken per cycle while in_ready_o is high. A string's verdict
// passes the token queue and the check stage's snapshot and output registers.
// The next string may start right after the last byte of the previous one.
// Reset clears all control and parser state; no clearing pass is needed.
// A stalled output backs up through the check stage and the two-entry
// token queue before in_ready_o drops.
// ----------------------------------------------------------------------------
module timestamp_syntax_validator
  import tsv_pkg::*;
#(
  parameter int unsigned MAX_LENGTH = MaxLengthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_byte_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       valid_res_o
);

  logic   fr_valid, fr_ready;
  token_t fr_tok;
  logic   q_valid, q_ready;
  token_t q_tok;
  logic   snap_valid, snap_ready;
  snap_t  snap;

  tsv_front u_front (
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .is_last_i   (is_last_i),
    .tok_valid_o (fr_valid),
    .tok_o       (fr_tok),
    .tok_ready_i (fr_ready)
  );

  tsv_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_tok_i   (fr_tok),
    .pop_valid_o  (q_valid),
    .pop_tok_o    (q_tok),
    .pop_ready_i  (q_ready)
  );

  tsv_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .tok_valid_i  (q_valid),
    .tok_i        (q_tok),
    .tok_ready_o  (q_ready),
    .snap_valid_o (snap_valid),
    .snap_o       (snap),
    .snap_ready_i (snap_ready)
  );

  tsv_check u_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_valid_i (snap_valid),
    .snap_i       (snap),
    .snap_ready_o (snap_ready),
    .out_valid_o  (out_valid_o),
    .valid_res_o  (valid_res_o),
    .out_ready_i  (out_ready_i)
  );

endmodule

FILE: test/tb_timestamp_syntax_validator.sv
// ----------------------------------------------------------------------------
// tb_timestamp_syntax_validator
// Streams date-time strings byte by byte into the validator and checks each
// verdict against a typed value or a cycle-free model of the validator.
// A short table of hand-picked strings is followed by random strings,
// mostly well formed with random field values, some mutated and some pure
// noise, with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb_timestamp_syntax_validator;
  import tsv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          VerdictBad   = 0;
  localparam int          VerdictGood  = 1;
  localparam int          VerdictModel = -1;
  localparam int          RandomBytes  = 1350;
  localparam int unsigned StallLimit   = 2000;

  localparam logic [7:0] ChZero  = "0";
  localparam logic [7:0] ChNine  = "9";
  localparam logic [7:0] ChDash  = "-";
  localparam logic [7:0] ChPlus  = "+";
  localparam logic [7:0] ChColon = ":";
  localparam logic [7:0] ChDot   = ".";
  localparam logic [7:0] ChT     = "T";
  localparam logic [7:0] ChZ     = "Z";

  typedef enum logic [3:0] {
    PH_FIXED,
    PH_SECONDS_DONE,
    PH_DOT,
    PH_FRACTION,
    PH_ZH1,
    PH_ZH2,
    PH_ZCOLON,
    PH_ZM1,
    PH_ZM2,
    PH_DONE
  } phase_e;

  typedef enum int {
    MUT_REPLACE,
    MUT_DROP,
    MUT_INSERT,
    MUT_CUT,
    MUT_APPEND
  } mutation_e;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_byte_i = 8'h00;
  logic       is_last_i   = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic       valid_res_o;

  // parser shadow state
  logic [6:0]  char_count;
  phase_e      phase;
  logic [13:0] year_acc;
  logic [6:0]  mon_acc, day_acc, hr_acc, min_acc, sec_acc;
  zone_sign_e  zsign;
  logic [6:0]  zhr, zmin;
  logic        bad;

  logic        verdict_q [$];
  int          typed_verdict_q [$];
  logic [7:0]  str_q [$];
  string       plan_text [$];
  int          plan_verdict [$];
  int          plan_nul [$];

  int unsigned mismatches    = 0;
  int unsigned strings_sent  = 0;
  int unsigned verdicts_seen = 0;
  int unsigned stall_cycles  = 0;
  logic        calm          = 1'b0;
  logic        want_verdict;
  int          typed_verdict;
  logic        moved;

  timestamp_syntax_validator #(
    .MAX_LENGTH(MaxLengthDef)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_byte_i(char_byte_i),
    .is_last_i  (is_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .valid_res_o(valid_res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic void clear_parse();
    char_count = '0;
    phase      = PH_FIXED;
    year_acc   = '0;
    mon_acc    = '0;
    day_acc    = '0;
    hr_acc     = '0;
    min_acc    = '0;
    sec_acc    = '0;
    zsign      = ZONE_NONE;
    zhr        = '0;
    zmin       = '0;
    bad        = 1'b0;
  endfunction

  function automatic void open_zone(input logic [7:0] c);
    if (c == ChZ) begin
      phase = PH_DONE;
    end else if (c == ChPlus) begin
      zsign = ZONE_PLUS;
      phase = PH_ZH1;
    end else if (c == ChDash) begin
      zsign = ZONE_MINUS;
      phase = PH_ZH1;
    end else begin
      bad = 1'b1;
    end
  endfunction

  function automatic void absorb_char(input logic [7:0] c);
    logic       dig;
    logic [3:0] d;
    logic [6:0] at;
    dig = (c >= ChZero) && (c <= ChNine);
    d   = dig ? 4'(c - ChZero) : 4'd0;
    at  = char_count;
    if (c == 8'h00) bad = 1'b1;
    // counter saturates at the length limit, the overflow sticks as an error
    if (char_count >= MaxLengthDef) bad = 1'b1;
    else char_count = char_count + 7'd1;
    if (bad) return;
    case (phase)
      PH_FIXED: begin
        if (at == 4 || at == 7) begin
          if (c != ChDash) bad = 1'b1;
        end else if (at == 10) begin
          if (c != ChT) bad = 1'b1;
        end else if (at == 13 || at == 16) begin
          if (c != ChColon) bad = 1'b1;
        end else if (!dig || at > 18) begin
          bad = 1'b1;
        end else begin
          if (at < 4) year_acc = 14'(year_acc * 10 + d);
          else if (at < 7) mon_acc = 7'(mon_acc * 10 + d);
          else if (at < 10) day_acc = 7'(day_acc * 10 + d);
          else if (at < 13) hr_acc = 7'(hr_acc * 10 + d);
          else if (at < 16) min_acc = 7'(min_acc * 10 + d);
          else sec_acc = 7'(sec_acc * 10 + d);
          if (at == 18) phase = PH_SECONDS_DONE;
        end
      end
      PH_SECONDS_DONE: begin
        if (c == ChDot) phase = PH_DOT;
        else open_zone(c);
      end
      PH_DOT: begin
        if (dig) phase = PH_FRACTION;
        else bad = 1'b1;
      end
      PH_FRACTION: begin
        if (!dig) open_zone(c);
      end
      PH_ZH1, PH_ZH2: begin
        if (dig) begin
          zhr = 7'(zhr * 10 + d);
          if (phase == PH_ZH1) phase = PH_ZH2;
          else phase = PH_ZCOLON;
        end else begin
          bad = 1'b1;
        end
      end
      PH_ZCOLON: begin
        if (c == ChColon) phase = PH_ZM1;
        else bad = 1'b1;
      end
      PH_ZM1, PH_ZM2: begin
        if (dig) begin
          zmin = 7'(zmin * 10 + d);
          if (phase == PH_ZM1) phase = PH_ZM2;
          else phase = PH_DONE;
        end else begin
          bad = 1'b1;
        end
      end
      default: bad = 1'b1;
    endcase
  endfunction

  function automatic logic judge_string();
    int   max_day;
    int   sod;
    int   off;
    logic leap;
    if (bad || phase != PH_DONE) return 1'b0;
    if (char_count < MinLength || char_count > MaxLengthDef) return 1'b0;
    if (zsign != ZONE_NONE) begin
      if (zhr > 23 || zmin > 59) return 1'b0;
      if (zsign == ZONE_MINUS && zhr == 0 && zmin == 0) return 1'b0;
    end
    if (mon_acc < 1 || mon_acc > 12) return 1'b0;
    if (hr_acc > 23 || min_acc > 59 || sec_acc > 60) return 1'b0;
    leap = (year_acc % 4 == 0) && (year_acc % 100 != 0 || year_acc % 400 == 0);
    case (mon_acc)
      4, 6, 9, 11: max_day = 30;
      2:           max_day = leap ? 29 : 28;
      default:     max_day = 31;
    endcase
    if (day_acc < 1 || day_acc > max_day) return 1'b0;
    // an offset is under one day, so only the first and last date can leave range
    sod = int'(hr_acc) * 3600 + int'(min_acc) * 60 + int'(sec_acc);
    off = int'(zhr) * 3600 + int'(zmin) * 60;
    if (zsign == ZONE_PLUS) sod = sod - off;
    else if (zsign == ZONE_MINUS) sod = sod + off;
    if (year_acc == 0 && mon_acc == 1 && day_acc == 1 && sod < 0) return 1'b0;
    if (year_acc == 9999 && mon_acc == 12 && day_acc == 31 && sod > 86399) return 1'b0;
    return 1'b1;
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // scoreboard: results first, since a verdict never leaves in its own request's cycle
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (out_valid_o && out_ready_i) begin
        moved = 1'b1;
        if (verdict_q.size() == 0) begin
          flag_mismatch($sformatf("verdict %b with no string pending", valid_res_o));
        end else begin
          want_verdict = verdict_q.pop_front();
          if (valid_res_o !== want_verdict)
            flag_mismatch($sformatf("string %0d: valid_res %b, expected %b",
                                    verdicts_seen, valid_res_o, want_verdict));
        end
        verdicts_seen++;
      end
      if (in_valid_i && in_ready_o) begin
        moved = 1'b1;
        absorb_char(char_byte_i);
        if (is_last_i) begin
          want_verdict  = judge_string();
          typed_verdict = typed_verdict_q.pop_front();
          if (typed_verdict != VerdictModel) want_verdict = typed_verdict[0];
          verdict_q.push_back(want_verdict);
          clear_parse();
        end
      end
      if (moved) stall_cycles = 0;
      else stall_cycles++;
      if (stall_cycles >= StallLimit) begin
        $display("watchdog: nothing accepted for %0d cycles", stall_cycles);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  always @(posedge clk_i) begin
    if (calm) begin
      out_ready_i <= 1'b1;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= 16);
    end
  end

  task automatic append_number(input int value, input int digits);
    int div;
    div = 1;
    repeat (digits - 1) div = div * 10;
    repeat (digits) begin
      str_q.push_back(8'(ChZero + (value / div) % 10));
      div = div / 10;
    end
  endtask

  task automatic send_string(input int verdict);
    int i;
    typed_verdict_q.push_back(verdict);
    for (i = 0; i < str_q.size(); i++) begin
      while (!calm && $urandom_range(0, 99) < 16) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      char_byte_i <= str_q[i];
      is_last_i   <= (i == str_q.size() - 1);
      @(posedge clk_i);
      while (!in_ready_o) @(posedge clk_i);
    end
    strings_sent++;
  endtask

  task automatic drain_verdicts();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (verdicts_seen < strings_sent) @(posedge clk_i);
  endtask

  task automatic add_row(input string text, input int verdict, input int nul_at);
    plan_text.push_back(text);
    plan_verdict.push_back(verdict);
    plan_nul.push_back(nul_at);
  endtask

  // mostly well formed strings with random fields, some mutated, some noise
  task automatic compose_random_string();
    int        kind, pick, n, at;
    int        yr, mo, dy, hr, mi, se, zh, zm;
    mutation_e mut;
    str_q.delete();
    kind = $urandom_range(0, 99);
    if (kind < 8) begin
      n = $urandom_range(1, 70);
      repeat (n) str_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    mo   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 12);
    dy   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(1, 31);
    hr   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23);
    mi   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59);
    se   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 60);
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        yr = 0;
        if ($urandom_range(0, 1)) begin mo = 1; dy = 1; end
      end
      1: begin
        yr = 9999;
        if ($urandom_range(0, 1)) begin mo = 12; dy = 31; end
      end
      2: yr = 400 * $urandom_range(0, 24);
      3: yr = 100 * $urandom_range(0, 99);
      4: yr = 4 * $urandom_range(0, 2499);
      default: yr = $urandom_range(0, 9999);
    endcase
    append_number(yr, 4);
    str_q.push_back(ChDash);
    append_number(mo, 2);
    str_q.push_back(ChDash);
    append_number(dy, 2);
    str_q.push_back(ChT);
    append_number(hr, 2);
    str_q.push_back(ChColon);
    append_number(mi, 2);
    str_q.push_back(ChColon);
    append_number(se, 2);
    pick = $urandom_range(0, 9);
    if (pick >= 5) begin
      str_q.push_back(ChDot);
      n = (pick == 9) ? $urandom_range(30, 50) : $urandom_range(1, 6);
      repeat (n) str_q.push_back(8'(ChZero + $urandom_range(0, 9)));
    end
    if ($urandom_range(0, 9) < 4) begin
      str_q.push_back(ChZ);
    end else begin
      str_q.push_back($urandom_range(0, 1) ? ChPlus : ChDash);
      pick = $urandom_range(0, 9);
      zh   = (pick == 0) ? $urandom_range(0, 99) : (pick < 3) ? 0 : $urandom_range(0, 23);
      pick = $urandom_range(0, 9);
      zm   = (pick == 0) ? $urandom_range(0, 99) : (pick < 3) ? 0 : $urandom_range(0, 59);
      append_number(zh, 2);
      str_q.push_back(ChColon);
      append_number(zm, 2);
    end
    if (kind < 32) begin
      at  = $urandom_range(0, str_q.size() - 1);
      mut = mutation_e'($urandom_range(0, 4));
      case (mut)
        MUT_REPLACE: str_q[at] = 8'($urandom_range(0, 255));
        MUT_DROP:    str_q.delete(at);
        MUT_INSERT:  str_q.insert(at, 8'($urandom_range(0, 255)));
        MUT_CUT:     while (str_q.size() > at + 1) void'(str_q.pop_back());
        default:     str_q.push_back(8'($urandom_range(1, 255)));
      endcase
    end
  endtask

  initial begin
    int i, k;
    int random_bytes;
    int n_random;
    clear_parse();

    add_row("2000-01-01T00:00:00Z", VerdictGood, -1);
    add_row("2000-01-01T00:00:00", VerdictBad, -1);
    add_row("Z", VerdictBad, -1);
    add_row("0000-01-01T00:00:00Z", VerdictGood, -1);
    add_row("0000-01-01T00:00:00+00:01", VerdictBad, -1);
    add_row("0000-01-01T00:30:00+00:30", VerdictGood, -1);
    add_row("9999-12-31T23:59:59Z", VerdictGood, -1);
    add_row("9999-12-31T23:59:60Z", VerdictBad, -1);
    add_row("9999-12-31T23:59:59-00:01", VerdictBad, -1);
    add_row("9999-12-31T00:00:00-23:59", VerdictGood, -1);
    add_row("2024-06-15T12:00:00-00:00", VerdictBad, -1);
    add_row("2024-06-15T12:00:00+00:00", VerdictGood, -1);
    add_row("2024-06-15T12:00:00+24:00", VerdictBad, -1);
    add_row("2024-06-15T12:00:00+23:60", VerdictBad, -1);
    add_row("2000-02-29T23:59:60.5+23:59", VerdictGood, -1);
    add_row("1900-02-29T00:00:00Z", VerdictBad, -1);
    add_row("2000-13-01T00:00:00Z", VerdictBad, -1);
    add_row("2000-04-31T00:00:00Z", VerdictBad, -1);
    add_row("2000-01-01t00:00:00Z", VerdictBad, -1);
    add_row("2000-01-01T24:00:00Z", VerdictBad, -1);
    add_row("2000-01-01T00:00:00ZZ", VerdictBad, -1);
    add_row("2000-01-01T00:00:00.Z", VerdictBad, -1);
    add_row("2000-01-01T00:00:00Z", VerdictBad, 5);
    add_row("2000-01-01T00:00:00\377", VerdictBad, -1);
    add_row("1999-09-09T09:09:09.999Z", VerdictGood, -1);
    // right at and one past the length limit
    add_row("2000-01-01T00:00:00.0123456789012345678901234567890123456789012Z",
            VerdictModel, -1);
    add_row("2000-01-01T00:00:00.01234567890123456789012345678901234567890123Z",
            VerdictModel, -1);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (k = 0; k < plan_text.size(); k++) begin
      str_q.delete();
      for (i = 0; i < plan_text[k].len(); i++) begin
        if (i == plan_nul[k]) str_q.push_back(8'h00);
        else str_q.push_back(plan_text[k][i]);
      end
      send_string(plan_verdict[k]);
    end
    drain_verdicts();

    random_bytes = 0;
    n_random     = 0;
    while (random_bytes < RandomBytes) begin
      calm <= (n_random >= 20 && n_random < 36);
      if (n_random % 30 == 29) drain_verdicts();
      compose_random_string();
      random_bytes = random_bytes + str_q.size();
      send_string(VerdictModel);
      n_random++;
    end
    calm <= 1'b0;

    drain_verdicts();
    repeat (8) @(posedge clk_i);
    if (verdict_q.size() != 0)
      flag_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
